### sv/cpcc_pkg.sv
// ----------------------------------------------------------------------------
// cpcc_pkg
// Types, constants, microcode and saturation helpers shared by the
// cascaded PI converter control block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcc_pkg;

    localparam int STEP_W = 5;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int SAT_W = PROD_W - 16;
    localparam int SUM_W = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] Q_ZERO = 32'sd0;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sd2147483648);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_REF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_KP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_KI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_OUT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_OUT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_KP = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_KI = 3'd7;

    // datapath operations
    typedef logic [3:0] cpcc_op_t;
    localparam cpcc_op_t OP_NOP = 4'd0;
    localparam cpcc_op_t OP_ERR = 4'd1;
    localparam cpcc_op_t OP_DIFF = 4'd2;
    localparam cpcc_op_t OP_MULP = 4'd3;
    localparam cpcc_op_t OP_MULI = 4'd4;
    localparam cpcc_op_t OP_ACC1 = 4'd5;
    localparam cpcc_op_t OP_ACC2 = 4'd6;
    localparam cpcc_op_t OP_CLAMP = 4'd7;
    localparam cpcc_op_t OP_MULB = 4'd8;
    localparam cpcc_op_t OP_BOOST = 4'd9;
    localparam cpcc_op_t OP_MULPWM = 4'd10;
    localparam cpcc_op_t OP_OUT = 4'd11;

    // loop select
    localparam logic LOOP_V = 1'b0;
    localparam logic LOOP_C = 1'b1;

    // sequencing
    typedef logic [1:0] cpcc_jmp_t;
    localparam cpcc_jmp_t JMP_NEXT = 2'd0;
    localparam cpcc_jmp_t JMP_WAIT_IN = 2'd1;
    localparam cpcc_jmp_t JMP_BUCK = 2'd2;
    localparam cpcc_jmp_t JMP_OUT = 2'd3;

    localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
    localparam logic [STEP_W-1:0] STEP_CUR_ERR = 5'd10;

    typedef struct packed {
        cpcc_op_t           op;
        logic               loop;
        cpcc_jmp_t          jmp;
        logic [STEP_W-1:0]  target;
    } cpcc_uword_t;

    typedef struct packed {
        logic               load;
        cpcc_op_t           op;
        logic               loop;
    } cpcc_ctrl_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] voltage_ref;
        logic [23:0]        voltage_kp;
        logic [23:0]        voltage_ki;
        logic signed [31:0] voltage_out_min;
        logic signed [31:0] voltage_out_max;
        logic [23:0]        current_kp;
        logic [23:0]        current_ki;
    } cpcc_cfg_t;

    typedef struct packed {
        logic signed [31:0] main_voltage;
        logic signed [31:0] battery_voltage;
        logic signed [31:0] battery_current;
    } cpcc_in_t;

    typedef struct packed {
        logic [15:0]        pwm_compare;
        logic signed [31:0] current_target;
        logic [16:0]        duty_value;
    } cpcc_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < SAT_LO)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic cpcc_uword_t uw(input cpcc_op_t op, input logic loop,
                                       input cpcc_jmp_t jmp,
                                       input logic [STEP_W-1:0] target);
        cpcc_uword_t w;
        w.op = op;
        w.loop = loop;
        w.jmp = jmp;
        w.target = target;
        return w;
    endfunction

    // control store
    function automatic cpcc_uword_t ucode(input logic [STEP_W-1:0] s);
        cpcc_uword_t w;
        unique case (s)
            5'd0:    w = uw(OP_NOP, LOOP_V, JMP_WAIT_IN, STEP_IDLE);
            5'd1:    w = uw(OP_ERR, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd2:    w = uw(OP_DIFF, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd3:    w = uw(OP_MULP, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd4:    w = uw(OP_MULI, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd5:    w = uw(OP_ACC1, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd6:    w = uw(OP_ACC2, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd7:    w = uw(OP_CLAMP, LOOP_V, JMP_BUCK, STEP_CUR_ERR);
            5'd8:    w = uw(OP_MULB, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd9:    w = uw(OP_BOOST, LOOP_V, JMP_NEXT, STEP_IDLE);
            5'd10:   w = uw(OP_ERR, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd11:   w = uw(OP_DIFF, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd12:   w = uw(OP_MULP, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd13:   w = uw(OP_MULI, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd14:   w = uw(OP_ACC1, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd15:   w = uw(OP_ACC2, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd16:   w = uw(OP_CLAMP, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd17:   w = uw(OP_MULPWM, LOOP_C, JMP_NEXT, STEP_IDLE);
            5'd18:   w = uw(OP_OUT, LOOP_C, JMP_OUT, STEP_IDLE);
            default: w = uw(OP_NOP, LOOP_V, JMP_OUT, STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### sv/cpcc_datapath.sv
// ----------------------------------------------------------------------------
// cpcc_datapath
// Shared PI datapath: one subtract/saturate unit, one registered multiplier,
// accumulate and clamp, driven one operation per cycle by the sequencer unless it waits for input or output.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcc_datapath #(
    parameter int PWM_PERIOD = 1000
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cpcc_pkg::cpcc_ctrl_t ctrl,
    input  wire cpcc_pkg::cpcc_cfg_t  cfg,
    input  wire cpcc_pkg::cpcc_in_t   in_data,
    output cpcc_pkg::cpcc_out_t       result
);

    cpcc_pkg::cpcc_in_t in_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] diff_reg;
    logic signed [cpcc_pkg::PROD_W-1:0] prod_reg;
    logic signed [31:0] term_reg;
    logic signed [cpcc_pkg::SUM_W-1:0] sum_reg;
    logic signed [31:0] o_reg;
    logic signed [31:0] target_reg;
    logic [16:0] duty_reg;

    logic signed [31:0] v_acc_reg;
    logic signed [31:0] v_last_reg;
    logic signed [31:0] c_acc_reg;
    logic signed [31:0] c_last_reg;

    logic signed [31:0] ref_l;
    logic signed [31:0] meas_l;
    logic signed [31:0] last_l;
    logic signed [31:0] acc_l;
    logic [23:0] kp_l;
    logic [23:0] ki_l;
    logic signed [31:0] lo_l;
    logic signed [31:0] hi_l;

    logic signed [cpcc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cpcc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [cpcc_pkg::PROD_W-1:0] mul_full;
    logic signed [31:0] prod_sat;
    logic signed [31:0] sub_a;
    logic signed [31:0] sub_b;
    logic signed [31:0] sub_sat;
    logic signed [31:0] sum_sat;
    logic signed [31:0] clamp_hi;
    logic signed [31:0] clamp_val;

    always_comb
    begin
        if (ctrl.loop == cpcc_pkg::LOOP_C)
        begin
            ref_l = target_reg;
            meas_l = in_reg.battery_current;
            last_l = c_last_reg;
            acc_l = c_acc_reg;
            kp_l = cfg.current_kp;
            ki_l = cfg.current_ki;
            lo_l = cpcc_pkg::Q_ZERO;
            hi_l = cpcc_pkg::Q_ONE;
        end
        else
        begin
            ref_l = cfg.voltage_ref;
            meas_l = cfg.mode ? in_reg.main_voltage : in_reg.battery_voltage;
            last_l = v_last_reg;
            acc_l = v_acc_reg;
            kp_l = cfg.voltage_kp;
            ki_l = cfg.voltage_ki;
            lo_l = cfg.voltage_out_min;
            hi_l = cfg.voltage_out_max;
        end
    end

    // error and error difference share one subtractor
    always_comb
    begin
        if (ctrl.op == cpcc_pkg::OP_DIFF)
        begin
            sub_a = err_reg;
            sub_b = last_l;
        end
        else
        begin
            sub_a = ref_l;
            sub_b = meas_l;
        end
    end

    assign sub_sat = cpcc_pkg::sat32(cpcc_pkg::SAT_W'(sub_a) - cpcc_pkg::SAT_W'(sub_b));

    always_comb
    begin
        unique case (ctrl.op)
            cpcc_pkg::OP_MULP:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, kp_l});
            end
            cpcc_pkg::OP_MULI:
            begin
                mul_a = err_reg;
                mul_b = $signed({1'b0, ki_l});
            end
            cpcc_pkg::OP_MULB:
            begin
                // current loop output stays within zero and one
                mul_a = target_reg;
                mul_b = -c_acc_reg[cpcc_pkg::MUL_B_W-1:0];
            end
            cpcc_pkg::OP_MULPWM:
            begin
                mul_a = cpcc_pkg::Q_ONE - $signed({15'b0, duty_reg});
                mul_b = cpcc_pkg::MUL_B_W'(PWM_PERIOD);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign prod_sat = cpcc_pkg::sat32(prod_reg[cpcc_pkg::PROD_W-1:16]);
    assign sum_sat = cpcc_pkg::sat32(cpcc_pkg::SAT_W'(sum_reg) + cpcc_pkg::SAT_W'(term_reg));

    // max clamp first, then min, so min wins on crossed limits
    assign clamp_hi = (o_reg > hi_l) ? hi_l : o_reg;
    assign clamp_val = (clamp_hi < lo_l) ? lo_l : clamp_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_acc_reg <= '0;
            v_last_reg <= '0;
            c_acc_reg <= '0;
            c_last_reg <= '0;
        end
        else
        begin
            if (ctrl.op == cpcc_pkg::OP_DIFF)
            begin
                if (ctrl.loop == cpcc_pkg::LOOP_C)
                begin
                    c_last_reg <= err_reg;
                end
                else
                begin
                    v_last_reg <= err_reg;
                end
            end
            if (ctrl.op == cpcc_pkg::OP_CLAMP)
            begin
                if (ctrl.loop == cpcc_pkg::LOOP_C)
                begin
                    c_acc_reg <= clamp_val;
                end
                else
                begin
                    v_acc_reg <= clamp_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            in_reg <= in_data;
        end
        unique case (ctrl.op)
            cpcc_pkg::OP_ERR:
            begin
                err_reg <= sub_sat;
            end
            cpcc_pkg::OP_DIFF:
            begin
                diff_reg <= sub_sat;
            end
            cpcc_pkg::OP_MULP, cpcc_pkg::OP_MULB, cpcc_pkg::OP_MULPWM:
            begin
                prod_reg <= mul_full;
            end
            cpcc_pkg::OP_MULI:
            begin
                term_reg <= prod_sat;
                prod_reg <= mul_full;
            end
            cpcc_pkg::OP_ACC1:
            begin
                sum_reg <= cpcc_pkg::SUM_W'(acc_l) + cpcc_pkg::SUM_W'(term_reg);
                term_reg <= prod_sat;
            end
            cpcc_pkg::OP_ACC2:
            begin
                o_reg <= sum_sat;
            end
            cpcc_pkg::OP_CLAMP:
            begin
                if (ctrl.loop == cpcc_pkg::LOOP_C)
                begin
                    duty_reg <= clamp_val[16:0];
                end
                else
                begin
                    target_reg <= clamp_val;
                end
            end
            cpcc_pkg::OP_BOOST:
            begin
                target_reg <= prod_sat;
            end
            default:
            begin
            end
        endcase
    end

    // product is non-negative here, so the floor is a plain shift
    assign result.pwm_compare = prod_reg[31:16];
    assign result.current_target = target_reg;
    assign result.duty_value = duty_reg;

endmodule

`default_nettype wire

### sv/cascaded_pi_converter_control.sv
// ----------------------------------------------------------------------------
// cascaded_pi_converter_control
// Cascaded incremental PI control: outer voltage loop feeding an inner
// current loop, with PWM compare output, sequenced from a microcode store.
// ----------------------------------------------------------------------------
//  channel   signals                          width  role
//  in        in_valid / in_ready / in_data    96     measurement request
//  out       out_valid / out_ready / out_data 65     control result request
//  cfg       cfg_we / cfg_index / cfg_data    3+32   register write, no wait
//
//  an accepted request runs 16 microcode steps in buck mode and 18 in boost
//  mode on one shared 32x25 multiplier, after the idle step that accepts it
//  the next request is taken as soon as the program returns to idle, while
//  the previous result may still wait in the output register
//  a result stalls the program only if the output register is still full
//  reset clears the loop state and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_pi_converter_control #(
    parameter int PWM_PERIOD = 1000
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire cpcc_pkg::cpcc_in_t                   in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output cpcc_pkg::cpcc_out_t                       out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [cpcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cpcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [cpcc_pkg::STEP_W-1:0] step_reg;
    logic [cpcc_pkg::STEP_W-1:0] step_next;
    cpcc_pkg::cpcc_uword_t uword;
    cpcc_pkg::cpcc_ctrl_t ctrl;
    cpcc_pkg::cpcc_cfg_t cfg_reg;
    cpcc_pkg::cpcc_out_t result;
    cpcc_pkg::cpcc_out_t out_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_accept;
    logic out_full;
    logic out_load;

    assign uword = cpcc_pkg::ucode(step_reg);
    assign in_ready = (uword.jmp == cpcc_pkg::JMP_WAIT_IN);
    assign in_accept = in_valid && in_ready;
    assign out_full = out_valid_reg && !out_ready;
    assign out_load = (uword.op == cpcc_pkg::OP_OUT) && !out_full;

    always_comb
    begin
        unique case (uword.jmp)
            cpcc_pkg::JMP_WAIT_IN:
                step_next = in_accept ? step_reg + 1'b1 : step_reg;
            cpcc_pkg::JMP_BUCK:
                step_next = cfg_reg.mode ? step_reg + 1'b1 : uword.target;
            cpcc_pkg::JMP_OUT:
                step_next = out_full ? step_reg : uword.target;
            default:
                step_next = step_reg + 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign ctrl.load = in_accept;
    assign ctrl.op = uword.op;
    assign ctrl.loop = uword.loop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cpcc_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg.mode <= 1'b0;
            cfg_reg.voltage_ref <= 32'sd262144;
            cfg_reg.voltage_kp <= 24'd229376;
            cfg_reg.voltage_ki <= 24'd9830;
            cfg_reg.voltage_out_min <= -32'sd65536;
            cfg_reg.voltage_out_max <= 32'sd65536;
            cfg_reg.current_kp <= 24'd9830;
            cfg_reg.current_ki <= 24'd655;
        end
        else
        begin
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cpcc_pkg::CFG_MODE:            cfg_reg.mode <= cfg_data[0];
                    cpcc_pkg::CFG_VOLTAGE_REF:     cfg_reg.voltage_ref <= cfg_data;
                    cpcc_pkg::CFG_VOLTAGE_KP:      cfg_reg.voltage_kp <= cfg_data[23:0];
                    cpcc_pkg::CFG_VOLTAGE_KI:      cfg_reg.voltage_ki <= cfg_data[23:0];
                    cpcc_pkg::CFG_VOLTAGE_OUT_MIN: cfg_reg.voltage_out_min <= cfg_data;
                    cpcc_pkg::CFG_VOLTAGE_OUT_MAX: cfg_reg.voltage_out_max <= cfg_data;
                    cpcc_pkg::CFG_CURRENT_KP:      cfg_reg.current_kp <= cfg_data[23:0];
                    cpcc_pkg::CFG_CURRENT_KI:      cfg_reg.current_ki <= cfg_data[23:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= result;
        end
    end

    cpcc_datapath #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .cfg     (cfg_reg),
        .in_data (in_data),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

### sv/cpcc_checker.sv
// ----------------------------------------------------------------------------
// cpcc_checker
// Port-level checks for the cascaded PI converter control block.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire cpcc_pkg::cpcc_out_t               out_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a new result appears as the program returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result without return to idle");

    // duty stays within zero and one
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duty_value <= 17'd65536)
        else $error("duty out of range");

endmodule

bind cascaded_pi_converter_control cpcc_checker u_cpcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
